// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/tpwi_pkg.sv =====
// types, constants and helpers of the waypoint interpolator
`default_nettype none

package tpwi_pkg;

   localparam int MAX_WAYPOINTS_DEF = 64;
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd10;
   localparam int POS_W = 32;
   localparam int QUAT_W = 16;
   localparam int MAG_W = POS_W + 1;
   localparam int DIV_STEPS = 7;
   localparam int DIV_STAGES = 5;
   localparam int NUM_W = DIV_STEPS * DIV_STAGES;
   localparam int REM_W = COUNT_W + 1;
   localparam int NUM_LANES = 3;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   typedef struct packed {
      logic [POS_W-1:0] sx;
      logic [POS_W-1:0] sy;
      logic [POS_W-1:0] sz;
      logic [POS_W-1:0] gz;
      logic [QUAT_W-1:0] qx;
      logic [QUAT_W-1:0] qy;
      logic [QUAT_W-1:0] qz;
      logic [QUAT_W-1:0] qw;
      logic [COUNT_W-1:0] lift;
      logic [COUNT_W-1:0] trans;
      logic [NUM_LANES-1:0] neg;
      logic [NUM_LANES-1:0][COUNT_W-1:0] dvs;
      logic [NUM_LANES-1:0][NUM_W-1:0] num;
      logic [NUM_LANES-1:0][REM_W-1:0] rem;
   } job_type;

   // n / 3 for n below 128
   function automatic logic [COUNT_W-1:0] lift_of(input logic [COUNT_W-1:0] n);
      logic [COUNT_W+8:0] p;
      p = {9'd0, n} * (COUNT_W+9)'(171);
      return p[COUNT_W+8:9];
   endfunction

   // one restoring division bit on every lane
   function automatic job_type div_step(input job_type j);
      job_type r;
      logic [REM_W:0] t;
      logic q;
      r = j;
      for (int k = 0; k < NUM_LANES; k++) begin
         t = {j.rem[k], j.num[k][NUM_W-1]};
         q = (t >= {2'b00, j.dvs[k]});
         if (q) begin
            t = t - {2'b00, j.dvs[k]};
         end
         r.rem[k] = t[REM_W-1:0];
         r.num[k] = {j.num[k][NUM_W-2:0], q};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/two_phase_waypoint_interpolator.sv =====
// top level of the two-phase waypoint interpolator
`default_nettype none
`include "assert_macros.svh"

// A transaction on start/busy carries one start and target pose; it yields
// min(waypoint_count, MAX_WAYPOINTS) waypoints, one per clock on rsp_strobe,
// lift points first, then translate points, the last one flagged. The first
// waypoint appears once the transaction has passed the DIV_STAGES registers
// of the pipelined span divider, the generator and the output register; the
// N waypoints of a request then follow on consecutive clocks. busy stays low
// while the divider pipeline has room, so up to DIV_STAGES further requests
// queue behind the one being emitted and follow it with no gap. A count of
// zero is taken and gives no waypoint. The receiver cannot stall.
module two_phase_waypoint_interpolator
   import tpwi_pkg::*;
#(
   parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [COUNT_W-1:0]       csr_wdata,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [POS_W-1:0]  req_start_x,
   input  wire logic signed [POS_W-1:0]  req_start_y,
   input  wire logic signed [POS_W-1:0]  req_start_z,
   input  wire logic signed [POS_W-1:0]  req_goal_x,
   input  wire logic signed [POS_W-1:0]  req_goal_y,
   input  wire logic signed [POS_W-1:0]  req_goal_z,
   input  wire logic signed [QUAT_W-1:0] req_goal_qx,
   input  wire logic signed [QUAT_W-1:0] req_goal_qy,
   input  wire logic signed [QUAT_W-1:0] req_goal_qz,
   input  wire logic signed [QUAT_W-1:0] req_goal_qw,
   output logic                          rsp_strobe,
   output logic signed [POS_W-1:0]       rsp_wp_x,
   output logic signed [POS_W-1:0]       rsp_wp_y,
   output logic signed [POS_W-1:0]       rsp_wp_z,
   output logic signed [QUAT_W-1:0]      rsp_wp_qx,
   output logic signed [QUAT_W-1:0]      rsp_wp_qy,
   output logic signed [QUAT_W-1:0]      rsp_wp_qz,
   output logic signed [QUAT_W-1:0]      rsp_wp_qw,
   output logic                          rsp_phase,
   output logic                          rsp_last_point
);

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_WAYPOINTS);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] n_eff;
   logic [COUNT_W-1:0] lift_n;
   logic               div_in_valid;
   logic               div_in_ready;
   job_type            div_in_job;
   logic               div_out_valid;
   job_type            div_out_job;
   logic               gen_load;

   logic [NUM_LANES-1:0][POS_W-1:0] a_pos;
   logic [NUM_LANES-1:0][POS_W-1:0] b_pos;
   logic [NUM_LANES-1:0][MAG_W-1:0] diff;
   logic [NUM_LANES-1:0][MAG_W-1:0] mag;

   logic                            gen_active_ff, gen_active_in;
   logic                            gen_phase_ff, gen_phase_in;
   logic [COUNT_W-1:0]              gen_idx_ff, gen_idx_in;
   job_type                         gen_job_ff;
   logic [NUM_LANES-1:0][MAG_W-1:0] gen_m_ff, gen_m_in;
   logic [NUM_LANES-1:0][REM_W-1:0] gen_r_ff, gen_r_in;
   logic                            gen_last;
   logic                            gen_lift_end;
   logic [REM_W:0]                  rsum;

   logic [NUM_LANES-1:0][POS_W-1:0] pt;

   logic                   rsp_strobe_ff;
   logic [POS_W-1:0]       wp_x_ff, wp_y_ff, wp_z_ff;
   logic [QUAT_W-1:0]      wp_qx_ff, wp_qy_ff, wp_qz_ff, wp_qw_ff;
   logic                   phase_ff, last_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // request preparation
   assign n_eff  = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
   assign lift_n = lift_of(n_eff);

   assign a_pos[LANE_X] = req_start_x;
   assign a_pos[LANE_Y] = req_start_y;
   assign a_pos[LANE_Z] = req_start_z;
   assign b_pos[LANE_X] = req_goal_x;
   assign b_pos[LANE_Y] = req_goal_y;
   assign b_pos[LANE_Z] = req_goal_z;

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         diff[k] = {b_pos[k][POS_W-1], b_pos[k]} - {a_pos[k][POS_W-1], a_pos[k]};
         mag[k]  = diff[k][MAG_W-1] ? (~diff[k] + MAG_W'(1)) : diff[k];
      end
      div_in_job       = '0;
      div_in_job.sx    = req_start_x;
      div_in_job.sy    = req_start_y;
      div_in_job.sz    = req_start_z;
      div_in_job.gz    = req_goal_z;
      div_in_job.qx    = req_goal_qx;
      div_in_job.qy    = req_goal_qy;
      div_in_job.qz    = req_goal_qz;
      div_in_job.qw    = req_goal_qw;
      div_in_job.lift  = lift_n;
      div_in_job.trans = n_eff - lift_n;
      for (int k = 0; k < NUM_LANES; k++) begin
         div_in_job.neg[k] = diff[k][MAG_W-1];
         div_in_job.num[k] = {(NUM_W-MAG_W)'(0), mag[k]};
      end
      div_in_job.dvs[LANE_X] = n_eff - lift_n;
      div_in_job.dvs[LANE_Y] = n_eff - lift_n;
      div_in_job.dvs[LANE_Z] = (lift_n == '0) ? COUNT_W'(1) : lift_n;
   end

   assign busy         = !div_in_ready;
   assign div_in_valid = start && (n_eff != '0);

   tpwi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_in_valid),
      .in_job    (div_in_job),
      .in_ready  (div_in_ready),
      .out_valid (div_out_valid),
      .out_job   (div_out_job),
      .out_ready (gen_load)
   );

   // waypoint generator
   assign gen_last     = gen_active_ff && gen_phase_ff && (gen_idx_ff == gen_job_ff.trans);
   assign gen_lift_end = gen_active_ff && !gen_phase_ff && (gen_idx_ff == gen_job_ff.lift);
   assign gen_load     = div_out_valid && (!gen_active_ff || gen_last);

   always_comb begin
      gen_active_in = gen_active_ff;
      gen_phase_in  = gen_phase_ff;
      gen_idx_in    = gen_idx_ff;
      gen_m_in      = gen_m_ff;
      gen_r_in      = gen_r_ff;
      rsum          = '0;
      if (gen_active_ff) begin
         gen_idx_in = gen_idx_ff + COUNT_W'(1);
         for (int k = 0; k < NUM_LANES; k++) begin
            if ((k == LANE_Z) != gen_phase_ff) begin
               rsum = {1'b0, gen_r_ff[k]} + {1'b0, gen_job_ff.rem[k]};
               if (rsum >= {2'b00, gen_job_ff.dvs[k]}) begin
                  rsum        = rsum - {2'b00, gen_job_ff.dvs[k]};
                  gen_m_in[k] = gen_m_ff[k] + gen_job_ff.num[k][MAG_W-1:0] + MAG_W'(1);
               end else begin
                  gen_m_in[k] = gen_m_ff[k] + gen_job_ff.num[k][MAG_W-1:0];
               end
               gen_r_in[k] = rsum[REM_W-1:0];
            end
         end
         if (gen_lift_end) begin
            gen_phase_in = 1'b1;
            gen_idx_in   = COUNT_W'(1);
         end
         if (gen_last) begin
            gen_active_in = 1'b0;
         end
      end
      if (gen_load) begin
         gen_active_in = 1'b1;
         gen_phase_in  = (div_out_job.lift == '0);
         gen_idx_in    = COUNT_W'(1);
         for (int k = 0; k < NUM_LANES; k++) begin
            gen_m_in[k] = div_out_job.num[k][MAG_W-1:0];
            gen_r_in[k] = div_out_job.rem[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      gen_phase_ff <= gen_phase_in;
      gen_idx_ff   <= gen_idx_in;
      gen_m_ff     <= gen_m_in;
      gen_r_ff     <= gen_r_in;
      if (gen_load) begin
         gen_job_ff <= div_out_job;
      end
      if (reset) begin
         gen_active_ff <= 1'b0;
      end else begin
         gen_active_ff <= gen_active_in;
      end
   end

   // output register
   always_comb begin
      pt[LANE_X] = gen_job_ff.sx;
      pt[LANE_Y] = gen_job_ff.sy;
      pt[LANE_Z] = gen_job_ff.sz;
      for (int k = 0; k < NUM_LANES; k++) begin
         if (gen_job_ff.neg[k]) begin
            pt[k] = pt[k] - gen_m_ff[k][POS_W-1:0];
         end else begin
            pt[k] = pt[k] + gen_m_ff[k][POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      wp_x_ff  <= gen_phase_ff ? pt[LANE_X] : gen_job_ff.sx;
      wp_y_ff  <= gen_phase_ff ? pt[LANE_Y] : gen_job_ff.sy;
      wp_z_ff  <= gen_phase_ff ? gen_job_ff.gz : pt[LANE_Z];
      wp_qx_ff <= gen_job_ff.qx;
      wp_qy_ff <= gen_job_ff.qy;
      wp_qz_ff <= gen_job_ff.qz;
      wp_qw_ff <= gen_job_ff.qw;
      phase_ff <= gen_phase_ff;
      last_ff  <= gen_last;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= gen_active_ff;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_wp_x       = wp_x_ff;
   assign rsp_wp_y       = wp_y_ff;
   assign rsp_wp_z       = wp_z_ff;
   assign rsp_wp_qx      = wp_qx_ff;
   assign rsp_wp_qy      = wp_qy_ff;
   assign rsp_wp_qz      = wp_qz_ff;
   assign rsp_wp_qw      = wp_qw_ff;
   assign rsp_phase      = phase_ff;
   assign rsp_last_point = last_ff;

   // checks
   `ASSERT_HOLDS(a_last_in_translate, clock, reset, !(rsp_strobe && rsp_last_point) || rsp_phase)
   `ASSERT_NEXT(a_lift_followed, clock, reset, rsp_strobe && !rsp_phase, rsp_strobe)
   `ASSERT_HOLDS(a_lift_nonempty, clock, reset, !(gen_active_ff && !gen_phase_ff) || (gen_job_ff.lift != '0))

endmodule

`default_nettype wire

// ===== hdl/tpwi_div.sv =====
// pipelined divider of the three coordinate spans by the phase lengths
`default_nettype none

module tpwi_div
   import tpwi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire job_type in_job,
   output logic         in_ready,
   output logic         out_valid,
   output job_type      out_job,
   input  wire logic    out_ready
);

   logic    [DIV_STAGES-1:0] v_ff;
   job_type [DIV_STAGES-1:0] job_ff;
   job_type [DIV_STAGES-1:0] job_in;
   logic    [DIV_STAGES-1:0] take;

   always_comb begin
      for (int s = DIV_STAGES - 1; s >= 0; s--) begin
         if (s == DIV_STAGES - 1) begin
            take[s] = !v_ff[s] || out_ready;
         end else begin
            take[s] = !v_ff[s] || take[s+1];
         end
      end
   end

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         job_in[s] = (s == 0) ? in_job : job_ff[(s == 0) ? 0 : s - 1];
         for (int b = 0; b < DIV_STEPS; b++) begin
            job_in[s] = div_step(job_in[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (take[s]) begin
            job_ff[s] <= job_in[s];
         end
      end
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            if (take[s]) begin
               v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s - 1];
            end
         end
      end
   end

   assign in_ready  = take[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_job   = job_ff[DIV_STAGES-1];

endmodule

`default_nettype wire
